// ===== rtl/slrp_pkg.sv =====
// shared types, phase codes and helpers of the service linking record parser
package slrp_pkg;

  // parser phases
  localparam logic [2:0] PH_AWAIT_HDR  = 3'd0;
  localparam logic [2:0] PH_REC_START  = 3'd1;
  localparam logic [2:0] PH_LSN_LOW    = 3'd2;
  localparam logic [2:0] PH_LIST_USAGE = 3'd3;
  localparam logic [2:0] PH_ID_BYTES   = 3'd4;

  // header flag bit positions (c/n, oe, p/d)
  localparam int HF_CN = 2;
  localparam int HF_OE = 1;
  localparam int HF_PD = 0;

  // record flag bit positions
  localparam int RF_IDLIST  = 4;
  localparam int RF_LA      = 3;
  localparam int RF_SH      = 2;
  localparam int RF_ILS     = 1;
  localparam int RF_DBSTART = 0;

  // result kinds
  localparam logic [1:0] KIND_HDR   = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_LINK  = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] linkage_set_number;
    logic        linkage_active;
    logic        soft_link;
    logic        international_set;
    logic        change_event;
    logic        continuation;
    logic [1:0]  list_qualifier;
    logic [31:0] id_value;
    logic [15:0] link_db_key;
    logic        last_of_record;
  } slrp_res_t;

  // identifier length in bytes
  function automatic logic [2:0] id_length(input logic pd, input logic ils);
    logic [2:0] len;
    if (pd) begin
      len = 3'd4;
    end else if (ils) begin
      len = 3'd3;
    end else begin
      len = 3'd2;
    end
    return len;
  endfunction

  function automatic logic mid_record(input logic [2:0] ph);
    return (ph == PH_LSN_LOW) || (ph == PH_LIST_USAGE) || (ph == PH_ID_BYTES);
  endfunction

endpackage

// ===== rtl/service_linking_record_parser_unit.sv =====
// top level of the service linking record parser: input register, parser core, result register
//
// usage
//   input channel: one byte of a service linking field per request, with
//   in_first_of_field on the type-0 header byte and in_last_of_field on the
//   final byte. each request yields zero or one result request on the out_
//   channel: record header, key or link identifier, or truncated record.
// datapath and throughput
//   a byte is held in the input register, is parsed by the core and lands
//   in the result register, which drives out_valid. one byte per cycle is
//   sustained while out_stall stays low; the parser state update in the core
//   is the loop that sets this.
// stalls
//   while the result register holds a stalled result, the input register
//   keeps its byte and in_stall rises only if that register is occupied;
//   no result is dropped or repeated.
// reset
//   rst_n low clears the valid bits of both registers and returns the parser
//   to waiting for a header byte with all record fields zero; no clearing pass is needed.
module service_linking_record_parser_unit import slrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_field,
  input  logic        in_last_of_field,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [11:0] out_linkage_set_number,
  output logic        out_linkage_active,
  output logic        out_soft_link,
  output logic        out_international_set,
  output logic        out_change_event,
  output logic        out_continuation,
  output logic [1:0]  out_list_qualifier,
  output logic [31:0] out_id_value,
  output logic [15:0] out_link_db_key,
  output logic        out_last_of_record
);

  // input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_first_r;
  logic       in_last_r;

  // result register
  logic      out_vld_r, out_vld_nxt;
  slrp_res_t out_res_r;

  logic      proc_en;
  logic      in_take;
  logic      res_valid;
  slrp_res_t res;

  // parse the held byte when the result register can take a result
  assign proc_en  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !proc_en;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (proc_en) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end

    if (proc_en) begin
      out_vld_nxt = res_valid;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  slrp_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (proc_en),
    .data_byte      (in_byte_r),
    .first_of_field (in_first_r),
    .last_of_field  (in_last_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_data_byte;
      in_first_r <= in_first_of_field;
      in_last_r  <= in_last_of_field;
    end
    if (proc_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_kind               = out_res_r.kind;
  assign out_linkage_set_number = out_res_r.linkage_set_number;
  assign out_linkage_active     = out_res_r.linkage_active;
  assign out_soft_link          = out_res_r.soft_link;
  assign out_international_set  = out_res_r.international_set;
  assign out_change_event       = out_res_r.change_event;
  assign out_continuation       = out_res_r.continuation;
  assign out_list_qualifier     = out_res_r.list_qualifier;
  assign out_id_value           = out_res_r.id_value;
  assign out_link_db_key        = out_res_r.link_db_key;
  assign out_last_of_record     = out_res_r.last_of_record;

endmodule

// ===== rtl/slrp_core.sv =====
// parser state registers and the per-byte next state and result logic
module slrp_core import slrp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  logic [7:0] data_byte,
  input  logic      first_of_field,
  input  logic      last_of_field,
  output logic      res_valid,
  output slrp_res_t res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  hdr_r, hdr_nxt;
  logic [4:0]  rec_r, rec_nxt;
  logic [11:0] set_r, set_nxt;
  logic [1:0]  qual_r, qual_nxt;
  logic [3:0]  ids_r, ids_nxt;
  logic        pend_r, pend_nxt;
  logic [2:0]  bytes_r, bytes_nxt;
  logic [31:0] acc_r, acc_nxt;

  logic [1:0]  kind;
  logic [31:0] idv;
  logic        last_rec;
  logic [31:0] acc_cat;
  logic [2:0]  bytes_dec;
  logic [3:0]  ids_dec;

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    rec_nxt   = rec_r;
    set_nxt   = set_r;
    qual_nxt  = qual_r;
    ids_nxt   = ids_r;
    pend_nxt  = pend_r;
    bytes_nxt = bytes_r;
    acc_nxt   = acc_r;
    res_valid = 1'b0;
    kind      = KIND_HDR;
    idv       = '0;
    last_rec  = 1'b0;
    acc_cat   = {acc_r[23:0], data_byte};
    bytes_dec = (bytes_r != 3'd0) ? bytes_r - 3'd1 : 3'd0;
    ids_dec   = (ids_r != 4'd0) ? ids_r - 4'd1 : 4'd0;

    if (first_of_field) begin
      // abandoned record reported with the old header flags
      if (mid_record(phase_r)) begin
        res_valid = 1'b1;
        kind      = KIND_TRUNC;
        last_rec  = 1'b1;
      end
      hdr_nxt   = data_byte[7:5];
      phase_nxt = last_of_field ? PH_AWAIT_HDR : PH_REC_START;
    end else begin
      unique case (phase_r)
        PH_REC_START: begin
          rec_nxt   = {data_byte[7:4], data_byte[7] & ~hdr_r[HF_CN]};
          set_nxt   = {data_byte[3:0], 8'h00};
          qual_nxt  = 2'd0;
          ids_nxt   = 4'd0;
          pend_nxt  = 1'b0;
          bytes_nxt = 3'd0;
          acc_nxt   = '0;
          phase_nxt = PH_LSN_LOW;
        end
        PH_LSN_LOW: begin
          set_nxt = {set_r[11:8], data_byte};
          if (rec_r[RF_IDLIST]) begin
            phase_nxt = PH_LIST_USAGE;
          end else begin
            res_valid = 1'b1;
            last_rec  = 1'b1;
            phase_nxt = PH_REC_START;
          end
        end
        PH_LIST_USAGE: begin
          qual_nxt  = data_byte[6:5];
          ids_nxt   = data_byte[3:0];
          res_valid = 1'b1;
          if (data_byte[3:0] == 4'd0) begin
            last_rec  = 1'b1;
            phase_nxt = PH_REC_START;
          end else begin
            pend_nxt  = 1'b1;
            bytes_nxt = id_length(hdr_r[HF_PD], rec_r[RF_ILS]);
            acc_nxt   = '0;
            phase_nxt = PH_ID_BYTES;
          end
        end
        PH_ID_BYTES: begin
          if (bytes_dec == 3'd0) begin
            res_valid = 1'b1;
            kind      = (pend_r && rec_r[RF_DBSTART]) ? KIND_KEY : KIND_LINK;
            idv       = acc_cat;
            last_rec  = (ids_dec == 4'd0);
            pend_nxt  = 1'b0;
            ids_nxt   = ids_dec;
            if (ids_dec != 4'd0) begin
              acc_nxt   = '0;
              bytes_nxt = id_length(hdr_r[HF_PD], rec_r[RF_ILS]);
            end else begin
              acc_nxt   = acc_cat;
              bytes_nxt = 3'd0;
              phase_nxt = PH_REC_START;
            end
          end else begin
            acc_nxt   = acc_cat;
            bytes_nxt = bytes_dec;
          end
        end
        default: begin
          // stray byte while waiting for a header
        end
      endcase

      if (last_of_field) begin
        if (mid_record(phase_nxt)) begin
          res_valid = 1'b1;
          kind      = KIND_TRUNC;
          idv       = '0;
          last_rec  = 1'b1;
        end
        phase_nxt = PH_AWAIT_HDR;
      end
    end

    res.kind               = kind;
    res.linkage_set_number = set_nxt;
    res.linkage_active     = rec_nxt[RF_LA];
    res.soft_link          = ~rec_nxt[RF_SH];
    res.international_set  = rec_nxt[RF_ILS];
    res.change_event       = ~rec_nxt[RF_IDLIST];
    res.continuation       = rec_nxt[RF_IDLIST] & hdr_r[HF_CN];
    res.list_qualifier     = qual_nxt;
    res.id_value           = idv;
    res.link_db_key        = {hdr_r[HF_OE], hdr_r[HF_PD], rec_nxt[RF_SH], rec_nxt[RF_ILS],
                              set_nxt};
    res.last_of_record     = last_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_AWAIT_HDR;
      hdr_r   <= '0;
      rec_r   <= '0;
      set_r   <= '0;
      qual_r  <= '0;
      ids_r   <= '0;
      pend_r  <= 1'b0;
      bytes_r <= '0;
      acc_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      rec_r   <= rec_nxt;
      set_r   <= set_nxt;
      qual_r  <= qual_nxt;
      ids_r   <= ids_nxt;
      pend_r  <= pend_nxt;
      bytes_r <= bytes_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

// ===== rtl/slrp_checker.sv =====
// port-level checks for the service linking record parser, bound to the top level
module slrp_checker import slrp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_first_of_field,
  input logic        in_last_of_field,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [11:0] out_linkage_set_number,
  input logic        out_linkage_active,
  input logic        out_soft_link,
  input logic        out_international_set,
  input logic        out_change_event,
  input logic        out_continuation,
  input logic [1:0]  out_list_qualifier,
  input logic [31:0] out_id_value,
  input logic [15:0] out_link_db_key,
  input logic        out_last_of_record
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_id_value)
      && $stable(out_link_db_key))
    else $error("stalled result changed");

  // truncated record always closes the record
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_TRUNC) |-> out_last_of_record)
    else $error("truncated result without last_of_record");

  // headers and truncations carry no identifier
  a_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == KIND_HDR) || (out_kind == KIND_TRUNC)) |-> out_id_value == '0)
    else $error("identifier on header or truncated result");

  // database key carries the set number and flags
  a_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_link_db_key[11:0] == out_linkage_set_number)
      && (out_link_db_key[13] == !out_soft_link)
      && (out_link_db_key[12] == out_international_set))
    else $error("link database key mismatch");

  // short form has no list and no key identifier
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_change_event |-> (out_list_qualifier == 2'd0) && !out_continuation
      && (out_kind != KIND_KEY))
    else $error("short-form record with list fields");

endmodule

bind service_linking_record_parser_unit slrp_checker u_slrp_checker (.*);

// ===== verif/linking_record_checker.sv =====
// checker for the service linking record parser: predicts results from accepted bytes and compares them
module linking_record_checker import slrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_field,
  input  logic        in_last_of_field,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [11:0] out_linkage_set_number,
  input  logic        out_linkage_active,
  input  logic        out_soft_link,
  input  logic        out_international_set,
  input  logic        out_change_event,
  input  logic        out_continuation,
  input  logic [1:0]  out_list_qualifier,
  input  logic [31:0] out_id_value,
  input  logic [15:0] out_link_db_key,
  input  logic        out_last_of_record,
  output int          fail_count,
  output int          results_waiting,
  output int          results_checked,
  output int          truncations_seen
);

  // parser state as the block should hold it
  logic [2:0]  phase;
  logic [2:0]  hdr_flags;
  logic [4:0]  rec_flags;
  logic [11:0] set_num;
  logic [1:0]  qual;
  logic [3:0]  ids_left;
  logic        first_id_pending;
  logic [2:0]  id_bytes_left;
  logic [31:0] id_acc;

  slrp_res_t awaited_results[$];

  function automatic logic record_open();
    return (phase == PH_LSN_LOW) || (phase == PH_LIST_USAGE) || (phase == PH_ID_BYTES);
  endfunction

  function automatic logic [2:0] ident_bytes();
    return hdr_flags[HF_PD] ? 3'd4 : (rec_flags[RF_ILS] ? 3'd3 : 3'd2);
  endfunction

  function automatic slrp_res_t make_result(logic [1:0] kind, logic [31:0] idv, logic last);
    slrp_res_t r;
    r.kind               = kind;
    r.linkage_set_number = set_num;
    r.linkage_active     = rec_flags[RF_LA];
    r.soft_link          = !rec_flags[RF_SH];
    r.international_set  = rec_flags[RF_ILS];
    r.change_event       = !rec_flags[RF_IDLIST];
    r.continuation       = rec_flags[RF_IDLIST] && hdr_flags[HF_CN];
    r.list_qualifier     = qual;
    r.id_value           = idv;
    r.link_db_key        = {hdr_flags[HF_OE], hdr_flags[HF_PD], rec_flags[RF_SH],
                            rec_flags[RF_ILS], set_num};
    r.last_of_record     = last;
    return r;
  endfunction

  // append one predicted result to the tail of the queue
  task automatic add_expected(input slrp_res_t r);
    awaited_results = {awaited_results, r};
  endtask

  task automatic parse_linking_byte(input logic [7:0] b, input logic first, input logic last);
    slrp_res_t  res;
    logic       have;
    logic [1:0] k;
    have = 1'b0;
    if (first) begin
      // a new header abandons an open record
      if (record_open()) begin
        add_expected(make_result(KIND_TRUNC, 32'd0, 1'b1));
      end
      hdr_flags = b[7:5];
      phase = last ? PH_AWAIT_HDR : PH_REC_START;
    end else begin
      case (phase)
        PH_REC_START: begin
          rec_flags = {b[7:4], 1'b0};
          if (rec_flags[RF_IDLIST] && !hdr_flags[HF_CN]) begin
            rec_flags[RF_DBSTART] = 1'b1;
          end
          set_num = {b[3:0], 8'h00};
          qual = 2'd0;
          ids_left = 4'd0;
          first_id_pending = 1'b0;
          id_bytes_left = 3'd0;
          id_acc = 32'd0;
          phase = PH_LSN_LOW;
        end
        PH_LSN_LOW: begin
          set_num[7:0] = b;
          if (rec_flags[RF_IDLIST]) begin
            phase = PH_LIST_USAGE;
          end else begin
            res = make_result(KIND_HDR, 32'd0, 1'b1);
            have = 1'b1;
            phase = PH_REC_START;
          end
        end
        PH_LIST_USAGE: begin
          qual = b[6:5];
          ids_left = b[3:0];
          if (ids_left == 4'd0) begin
            res = make_result(KIND_HDR, 32'd0, 1'b1);
            phase = PH_REC_START;
          end else begin
            res = make_result(KIND_HDR, 32'd0, 1'b0);
            first_id_pending = 1'b1;
            id_bytes_left = ident_bytes();
            id_acc = 32'd0;
            phase = PH_ID_BYTES;
          end
          have = 1'b1;
        end
        PH_ID_BYTES: begin
          id_acc = {id_acc[23:0], b};
          if (id_bytes_left != 3'd0) begin
            id_bytes_left = id_bytes_left - 3'd1;
          end
          if (id_bytes_left == 3'd0) begin
            k = (first_id_pending && rec_flags[RF_DBSTART]) ? KIND_KEY : KIND_LINK;
            first_id_pending = 1'b0;
            if (ids_left != 4'd0) begin
              ids_left = ids_left - 4'd1;
            end
            res = make_result(k, id_acc, ids_left == 4'd0);
            have = 1'b1;
            if (ids_left != 4'd0) begin
              id_acc = 32'd0;
              id_bytes_left = ident_bytes();
            end else begin
              phase = PH_REC_START;
            end
          end
        end
        default: begin
        end
      endcase
      // field ends inside a record
      if (last) begin
        if (record_open()) begin
          res = make_result(KIND_TRUNC, 32'd0, 1'b1);
          have = 1'b1;
        end
        phase = PH_AWAIT_HDR;
      end
      if (have) begin
        add_expected(res);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    slrp_res_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: kind %0d id %0h", out_kind, out_id_value);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      compare_field("kind", 32'(want.kind), 32'(out_kind));
      compare_field("linkage_set_number", 32'(want.linkage_set_number),
                    32'(out_linkage_set_number));
      compare_field("linkage_active", 32'(want.linkage_active), 32'(out_linkage_active));
      compare_field("soft_link", 32'(want.soft_link), 32'(out_soft_link));
      compare_field("international_set", 32'(want.international_set),
                    32'(out_international_set));
      compare_field("change_event", 32'(want.change_event), 32'(out_change_event));
      compare_field("continuation", 32'(want.continuation), 32'(out_continuation));
      compare_field("list_qualifier", 32'(want.list_qualifier), 32'(out_list_qualifier));
      compare_field("id_value", want.id_value, out_id_value);
      compare_field("link_db_key", 32'(want.link_db_key), 32'(out_link_db_key));
      compare_field("last_of_record", 32'(want.last_of_record), 32'(out_last_of_record));
      results_checked++;
      if (want.kind == KIND_TRUNC) begin
        truncations_seen++;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    results_waiting = 0;
    results_checked = 0;
    truncations_seen = 0;
  end

  // results are checked before the new byte is predicted, so a fresh
  // expectation can never pair with a result of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      phase = PH_AWAIT_HDR;
      hdr_flags = 3'd0;
      rec_flags = 5'd0;
      set_num = 12'd0;
      qual = 2'd0;
      ids_left = 4'd0;
      first_id_pending = 1'b0;
      id_bytes_left = 3'd0;
      id_acc = 32'd0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
      end
      if (in_valid && !in_stall) begin
        parse_linking_byte(in_data_byte, in_first_of_field, in_last_of_field);
      end
    end
    results_waiting = awaited_results.size();
  end

endmodule

// ===== verif/tb.sv =====
// testbench top of the service linking record parser: stimulus, back-pressure and verdict
module tb;

  // longest stretch with no request moving either way before the run is called hung
  localparam int QUIET_LIMIT = 1000;
  localparam int FIELD_BYTES_TARGET = 900;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_first_of_field;
  logic        in_last_of_field;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [11:0] out_linkage_set_number;
  logic        out_linkage_active;
  logic        out_soft_link;
  logic        out_international_set;
  logic        out_change_event;
  logic        out_continuation;
  logic [1:0]  out_list_qualifier;
  logic [31:0] out_id_value;
  logic [15:0] out_link_db_key;
  logic        out_last_of_record;

  int fail_count;
  int results_waiting;
  int results_checked;
  int truncations_seen;

  int quiet_cycles;
  int burst_left;
  bit pressure_armed;

  service_linking_record_parser_unit uut (.*);

  // watches both channels, predicts every result and counts mismatches
  linking_record_checker checker_i (.*);

  // clock, period 10
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hang detection: nothing accepted on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one byte request; the sender works in bursts with idle gaps between them
  // payload only changes at a falling edge and holds while stalled
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    int gap;
    if (burst_left == 0) begin
      // idle gap, then a new burst: mostly short, sometimes a long run with no gaps
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_first_of_field <= first;
    in_last_of_field <= last;
    // accepted at the first rising edge with stall low
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // one service linking field with random content: header, then one to three
  // records, short or long form, identifier lengths following p/d and ils;
  // now and then the field is cut at a random byte or left without its end mark
  task automatic send_random_field(output int sent);
    logic [7:0] field_q[$];
    logic [7:0] hdr;
    logic [7:0] rec_hi;
    logic [7:0] usage;
    logic       long_form;
    int         n_rec;
    int         n_ids;
    int         id_len;
    int         ending;
    int         end_idx;
    hdr = 8'($urandom);
    field_q = {field_q, hdr};
    n_rec = $urandom_range(1, 3);
    repeat (n_rec) begin
      long_form = ($urandom_range(0, 2) != 0);
      rec_hi = 8'($urandom);
      rec_hi[7] = long_form;
      field_q = {field_q, rec_hi};
      field_q = {field_q, 8'($urandom)};
      if (long_form) begin
        // mostly short identifier lists, a few up to the full count of 15
        n_ids = ($urandom_range(0, 11) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
        usage = 8'($urandom);
        usage[3:0] = 4'(n_ids);
        field_q = {field_q, usage};
        id_len = hdr[5] ? 4 : (rec_hi[4] ? 3 : 2);
        repeat (n_ids * id_len) field_q = {field_q, 8'($urandom)};
      end
    end
    // 0: cut at a random byte, 1: no end mark, otherwise a proper end
    ending = $urandom_range(0, 11);
    end_idx = (ending == 0) ? $urandom_range(0, field_q.size() - 1) : field_q.size() - 1;
    for (int i = 0; i <= end_idx; i++) begin
      send_byte(field_q[i], i == 0, (ending != 1) && (i == end_idx));
    end
    sent = end_idx + 1;
  endtask

  // receiver: segments of random stall patterns; once random traffic runs,
  // a long hold-off fills the block so that it has to stall its input
  initial begin : stall_pattern
    stall_mode_t mode;
    int          seg_len;
    int          holds_done;
    holds_done = 0;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      if (pressure_armed && (holds_done == 0 || $urandom_range(0, 15) == 0)) begin
        holds_done++;
        repeat (80) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      mode = stall_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(16, 120);
      repeat (seg_len) begin
        @(negedge clk);
        case (mode)
          STALL_NONE: begin
            out_stall <= 1'b0;
          end
          STALL_LIGHT: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          STALL_HEAVY: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall <= ~out_stall;
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    int field_bytes;
    int chunk;
    int n_stray;
    field_bytes = 0;
    burst_left = 0;
    pressure_armed = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_first_of_field = 1'b0;
    in_last_of_field = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // stray byte while waiting for a header, ignored
    send_byte(8'hFF, 1'b0, 1'b0);
    // header with c/n, oe and p/d all clear
    send_byte(8'h00, 1'b1, 1'b0);
    // short form, all flags set, largest set number
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    // long form, qualifier 3, two 2-byte ids: key id of all ones, then link id of zero
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h62, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    // international set with 3-byte id, abandoned by a new header mid-id
    send_byte(8'h92, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'hAB, 1'b0, 1'b0);
    send_byte(8'hCD, 1'b0, 1'b0);
    // header with c/n, oe and p/d set: continuation, 4-byte ids
    send_byte(8'hE0, 1'b1, 1'b0);
    // long form with an empty id list
    send_byte(8'hC0, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h20, 1'b0, 1'b0);
    // field ends after two bytes of a 4-byte id
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h05, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b1);
    // header that is the whole field
    send_byte(8'hA0, 1'b1, 1'b1);

    // random fields, with a sprinkle of stray bytes between them
    pressure_armed = 1'b1;
    while (field_bytes < FIELD_BYTES_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        n_stray = $urandom_range(1, 3);
        repeat (n_stray) send_byte(8'($urandom), 1'b0, 1'($urandom));
      end
      send_random_field(chunk);
      field_bytes += chunk;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then a few cycles to catch any extra result
    wait (results_waiting == 0);
    repeat (8) @(posedge clk);

    $display("run covered %0d random field bytes plus directed cases, %0d results checked",
             field_bytes, results_checked);
    $display("%0d of the results were truncated records", truncations_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/slrp_pkg.sv
rtl/slrp_core.sv
rtl/service_linking_record_parser_unit.sv
rtl/slrp_checker.sv
verif/linking_record_checker.sv
verif/tb.sv
